// ===== rtl/ordered_set_store_macros.svh =====
// Assertion macros for the ordered set store.
// Each macro expects clk and rst in scope at the place of use.
`ifndef ORDERED_SET_STORE_MACROS_SVH
`define ORDERED_SET_STORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define OSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_set_store: same-cycle check failed");

// Next-cycle implication.
`define OSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_set_store: next-cycle check failed");

`else

`define OSS_ASSERT_NOW(lbl, ante, cons)
`define OSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/oss_pkg.sv =====
package oss_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int ELEM_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] element;
  } req_t;

  typedef struct packed {
    logic       was_member;
    logic [5:0] stored_count;
    logic       is_full;
    logic       is_empty;
    logic       rejected;
  } res_t;

  // Per-request command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ===== rtl/oss_cell.sv =====
// One slot of the store: compare against the key, shift down on delete,
// load the key when this slot is the append position.
module oss_cell #(
  parameter int IDX        = 0,
  parameter int ELEM_WIDTH = oss_pkg::ELEM_WIDTH_DEF,
  parameter int CNT_W      = 6
) (
  input  logic                  clk,
  input  oss_pkg::cell_ctl_t    ctl,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]      count,
  input  logic [ELEM_WIDTH-1:0] right_data,
  input  logic                  shift_in,
  output logic [ELEM_WIDTH-1:0] data,
  output logic                  match,
  output logic                  shift_out
);
  import oss_pkg::*;

  logic live;

  assign live      = count > CNT_W'(IDX);
  assign match     = live && (data == key);
  // Shift from the matching slot upwards.
  assign shift_out = shift_in || match;

  always_ff @(posedge clk) begin
    if (ctl.del && shift_out) begin
      data <= right_data;
    end else if (ctl.ins && (count == CNT_W'(IDX))) begin
      data <= key;
    end
  end

endmodule

// ===== rtl/ordered_set_store.sv =====
// Channel | Ports                          | Direction | Payload
// --------+--------------------------------+-----------+--------------------------------
// request | req, req_valid, req_ready      | in        | op, element
// result  | res, res_valid, res_ready      | out       | was_member, count, flags
//
// One request per cycle: every cell compares its entry with the key in the
// same cycle, and the result lands in the output register at the next edge.
// Throughput is set by the output register: a new request is taken while the
// held result is being taken, so stalls on the result side hold the request side.
// Reset (rst, synchronous) empties the set and the output register; entry
// contents are not cleared, as slots at or above the count are never compared.
`include "ordered_set_store_macros.svh"

module ordered_set_store #(
  parameter int CAPACITY   = oss_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = oss_pkg::ELEM_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  oss_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_ready,
  output oss_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_ready
);
  import oss_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]       entry_count;
  logic [CntW-1:0]       count_next;
  logic [ELEM_WIDTH-1:0] key;
  logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]     shift_chain;
  logic [CAPACITY-1:0]   match;
  logic                  accept;
  logic                  member;
  logic                  full;
  logic                  rejected_next;
  cell_ctl_t             ctl;

  // Bits above the element width take no part.
  assign key       = ELEM_WIDTH'(req.element);
  assign accept    = req_valid && req_ready;
  assign req_ready = !res_valid || res_ready;
  assign member    = |match;
  assign full      = entry_count == CntW'(CAPACITY);

  assign shift_chain[0] = 1'b0;

  // Row of cells; cell i takes its neighbour's entry on a delete, the top cell
  // keeps its own (it falls out of the live range anyway).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] right_data;

    if (i == CAPACITY - 1) begin : g_top
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    oss_cell #(
      .IDX        (i),
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CntW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .count      (entry_count),
      .right_data (right_data),
      .shift_in   (shift_chain[i]),
      .data       (cell_data[i]),
      .match      (match[i]),
      .shift_out  (shift_chain[i+1])
    );
  end

  // Decode the request: commands to the cells and the count after the step.
  always_comb begin
    ctl           = '0;
    count_next    = entry_count;
    rejected_next = 1'b0;
    case (req.op)
      OP_INSERT: begin
        if (!member) begin
          if (full) begin
            rejected_next = 1'b1;
          end else begin
            ctl.ins    = accept;
            count_next = entry_count + CntW'(1);
          end
        end
      end
      OP_DELETE: begin
        if (member) begin
          ctl.del    = accept;
          count_next = entry_count - CntW'(1);
        end
      end
      OP_QUERY: begin
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= count_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold until taken, load on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.was_member   <= member;
      res.stored_count <= 6'(count_next);
      res.is_full      <= count_next == CntW'(CAPACITY);
      res.is_empty     <= count_next == '0;
      res.rejected     <= rejected_next;
    end
  end

  // Entries are distinct, so no two live cells may match the key.
  `OSS_ASSERT_NOW(a_single_match, 1'b1, $onehot0(match))
  // The count never runs past the capacity.
  `OSS_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CntW'(CAPACITY))
  // A refused insert only ever reports a full store.
  `OSS_ASSERT_NOW(a_reject_full, res_valid && res.rejected, res.is_full)
  // A clear request empties the set at the next edge.
  `OSS_ASSERT_NEXT(a_clear_empties, accept && (req.op == OP_CLEAR), entry_count == '0)

endmodule

// ===== test/tb_ordered_set_store.sv =====
`timescale 1ns / 100ps

module tb_ordered_set_store;
  import oss_pkg::*;

  // The store registers its answer at the edge that takes a request, so a short tail is
  // plenty once the last expected result is in.
  localparam int TAIL_CYCLES  = 8;
  // Cycles with no handshake on either side before the run is called hung.
  localparam int STALL_LIMIT  = 5000;
  localparam int POOL_SIZE    = 48;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 100;
  localparam logic [31:0] ELEM_MASK =
    (ELEM_WIDTH_DEF >= 32) ? '1 : ((32'd1 << ELEM_WIDTH_DEF) - 1);

  // Mirror of the set contents, kept in insertion order, plus the queue of
  // results the store owes us.
  class set_mirror;
    logic [31:0] members[$];
    res_t        pending_results[$];
    int          errors;

    function void note_request(req_t r);
      logic [31:0] value;
      int          pos;
      logic        refused;
      res_t        want;
      value   = r.element & ELEM_MASK;
      pos     = -1;
      refused = 1'b0;
      foreach (members[i]) begin
        if (pos < 0 && members[i] == value) begin
          pos = i;
        end
      end
      want.was_member = (pos >= 0);
      case (r.op)
        OP_INSERT: begin
          if (pos < 0) begin
            if (members.size() >= CAPACITY_DEF) begin
              refused = 1'b1;
            end else begin
              members.push_back(value);
            end
          end
        end
        OP_DELETE: begin
          // Later entries close the gap, which a queue delete does for us.
          if (pos >= 0) begin
            members.delete(pos);
          end
        end
        OP_QUERY: begin
        end
        OP_CLEAR: begin
          members.delete();
        end
        default: begin
        end
      endcase
      want.stored_count = 6'(members.size());
      want.is_full      = (members.size() == CAPACITY_DEF);
      want.is_empty     = (members.size() == 0);
      want.rejected     = refused;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [5:0] want, logic [5:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, actual %p",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("was_member", 6'(want.was_member), 6'(got.was_member));
      compare_field("stored_count", want.stored_count, got.stored_count);
      compare_field("is_full", 6'(want.is_full), 6'(got.is_full));
      compare_field("is_empty", 6'(want.is_empty), 6'(got.is_empty));
      compare_field("rejected", 6'(want.rejected), 6'(got.rejected));
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  req_t req       = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  res_t res;
  logic res_valid;
  logic res_ready = 1'b0;

  set_mirror   mirror = new();
  bit          steady = 1'b0;     // no gaps on either side while set
  int          hold_cycles = 0;
  int          idle_cycles = 0;
  logic [31:0] pool[POOL_SIZE];

  ordered_set_store DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one request, hold it until taken, note it, then idle for any gap drawn.
  task automatic send_request(input op_t kind, input logic [31:0] value);
    req_t item;
    int   gap;
    item.op      = kind;
    item.element = value;
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mirror.note_request(item);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  // With nothing outstanding, valid is already low and is left alone.
  task automatic wait_for_drain();
    if (mirror.pending_results.size() != 0) begin
      req_valid <= 1'b0;
      while (mirror.pending_results.size() != 0) @(posedge clk);
    end
  endtask

  function automatic op_t pick_op(int phase_kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase_kind)
      0: begin  // grow the set towards full and beyond
        if (roll < 75) return OP_INSERT;
        if (roll < 86) return OP_DELETE;
        if (roll < 99) return OP_QUERY;
        return OP_CLEAR;
      end
      1: begin
        if (roll < 40) return OP_INSERT;
        if (roll < 70) return OP_DELETE;
        if (roll < 95) return OP_QUERY;
        return OP_CLEAR;
      end
      default: begin  // shrink, mostly by deletes anywhere in the order
        if (roll < 15) return OP_INSERT;
        if (roll < 75) return OP_DELETE;
        if (roll < 98) return OP_QUERY;
        return OP_CLEAR;
      end
    endcase
  endfunction

  // Draw mostly from a small pool so hits, duplicates and a full store occur.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 92 && mirror.members.size() != 0) begin
      return mirror.members[$urandom_range(0, mirror.members.size() - 1)];
    end
    return $urandom();
  endfunction

  // Result side: check what is taken, then decide on ready for the next edge.
  always @(posedge clk) begin
    if (res_valid && res_ready) begin
      mirror.check_result(res);
    end
    if (hold_cycles > 0) begin
      res_ready <= 1'b0;
      hold_cycles--;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      res_ready   <= 1'b0;
      hold_cycles = pick_gap();
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h0000_0001;
    pool[4] = 32'h5555_5555;
    pool[5] = 32'hAAAA_AAAA;
    for (int i = 6; i < POOL_SIZE; i++) begin
      pool[i] = $urandom();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extremes, duplicates, compaction, clear.
    send_request(OP_QUERY, 32'h0000_0000);   // lookup on an empty set
    send_request(OP_DELETE, 32'hFFFF_FFFF);  // delete from an empty set
    send_request(OP_CLEAR, 32'h0000_0000);   // clear an empty set
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);  // already present: no change
    send_request(OP_QUERY, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h1234_5678);   // absent
    send_request(OP_DELETE, 32'h8000_0000);  // middle entry, later ones shift
    send_request(OP_QUERY, 32'h0000_0001);
    send_request(OP_QUERY, 32'h8000_0000);
    send_request(OP_DELETE, 32'h0000_0000);  // first entry
    send_request(OP_DELETE, 32'h7FFF_FFFF);  // last entry
    send_request(OP_DELETE, 32'h5555_5555);  // absent
    send_request(OP_INSERT, 32'hAAAA_AAAA);
    send_request(OP_CLEAR, 32'h0000_0001);   // membership before the clear
    send_request(OP_QUERY, 32'h0000_0001);
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_CLEAR, 32'hDEAD_BEEF);   // clear with an absent key
    wait_for_drain();

    // Random phases: fill, mixed, drain in turn; every fourth without gaps.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 2 || $urandom_range(0, 2) == 0) begin
        wait_for_drain();
      end
      steady = (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_op(phase % 3), pick_value());
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
